// ----- hw/rtl/mlpp_pkg.sv -----
`timescale 1ns / 1ps

package mlpp_pkg;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam int PAGE_ROWS = 8;
	localparam int WORD_BITS = 64;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_op_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] row;
		logic [6:0] col;
		logic       pixel;
		logic [2:0] page_sel;
	} in_t;

	typedef struct packed {
		logic [2:0]  page_out;
		logic [3:0]  column_group;
		logic [63:0] packed_bytes;
		logic        last;
	} out_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [2:0] page;
		logic [6:0] col;
		logic [2:0] rsub;
		logic       pixel;
	} cmd_t;

endpackage

// ----- hw/rtl/mono_lcd_page_packer_core.sv -----
`timescale 1ns / 1ps

// Monochrome framebuffer of SCREEN_WIDTH x SCREEN_HEIGHT pixels that is read out in LCD page
// format. The store is kept as words of eight column bytes, one word per page and group of
// eight columns, in a single-port memory. A pixel write is a read-modify-write of one word: it
// is read when the back end takes the command and written back in the write state; a readout
// gives SCREEN_WIDTH/8 results at one per cycle while the output is taken. A clear sweeps the
// memory one word per cycle, SCREEN_WIDTH*SCREEN_HEIGHT/64 words (128 at the default size);
// the same sweep runs after reset, and no input transaction is accepted while a sweep is
// running. A two-entry command queue sits between the input decode and the memory engine, so
// any item is taken at up to one per cycle during a write or readout, until the queue fills.

module mono_lcd_page_packer_core #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mlpp_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mlpp_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);

	logic           invert_q;
	logic           clearing;
	logic           fifo_full;
	logic           push;
	mlpp_pkg::cmd_t push_cmd;
	logic           cmd_valid;
	logic           pop;
	mlpp_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (cfg_we) begin
			invert_q <= cfg_wdata;
		end
	end

	mlpp_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.clearing (clearing),
		.fifo_full(fifo_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mlpp_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.cmd_valid(cmd_valid),
		.pop      (pop),
		.cmd      (cmd)
	);

	mlpp_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.invert   (invert_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.pop      (pop),
		.clearing (clearing),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// ----- hw/rtl/mlpp_front.sv -----
`timescale 1ns / 1ps

module mlpp_front #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic          in_valid,
	output logic          in_ready,
	input  mlpp_pkg::in_t in_data,
	input  logic          clearing,
	input  logic          fifo_full,
	output logic          push,
	output mlpp_pkg::cmd_t push_cmd
);

	localparam int PAGES = SCREEN_HEIGHT / mlpp_pkg::PAGE_ROWS;
	localparam int VIS_H = PAGES * mlpp_pkg::PAGE_ROWS;
	localparam int VIS_W = (SCREEN_WIDTH / 8) * 8;

	logic keep;

	assign in_ready = !fifo_full && !clearing;

	// Pixels outside the whole pages and column groups can never be read out, so they are dropped.
	always_comb begin
		keep = 1'b0;
		push_cmd.op = mlpp_pkg::CMD_WRITE;
		push_cmd.page = in_data.row[5:3];
		push_cmd.col = in_data.col;
		push_cmd.rsub = in_data.row[2:0];
		push_cmd.pixel = in_data.pixel;
		case (in_data.mode)
			mlpp_pkg::MODE_WRITE: begin
				keep = (32'(in_data.row) < VIS_H) && (32'(in_data.col) < VIS_W);
			end
			mlpp_pkg::MODE_CLEAR: begin
				keep = 1'b1;
				push_cmd.op = mlpp_pkg::CMD_CLEAR;
			end
			mlpp_pkg::MODE_READ: begin
				keep = 32'(in_data.page_sel) < PAGES;
				push_cmd.op = mlpp_pkg::CMD_READ;
				push_cmd.page = in_data.page_sel;
				push_cmd.col = '0;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = in_valid && in_ready && keep;

endmodule

// ----- hw/rtl/mlpp_cmd_fifo.sv -----
`timescale 1ns / 1ps

module mlpp_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mlpp_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           cmd_valid,
	input  logic           pop,
	output mlpp_pkg::cmd_t cmd
);

	mlpp_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/mlpp_back.sv -----
`timescale 1ns / 1ps

module mlpp_back #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           invert,
	input  logic           cmd_valid,
	input  mlpp_pkg::cmd_t cmd,
	output logic           pop,
	output logic           clearing,
	output logic           out_valid,
	input  logic           out_ready,
	output mlpp_pkg::out_t out_data
);

	localparam int GROUPS = SCREEN_WIDTH / 8;
	localparam int PAGES  = SCREEN_HEIGHT / mlpp_pkg::PAGE_ROWS;
	localparam int DEPTH  = GROUPS * PAGES;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_WRITE = 4'b0100,
		S_READ  = 4'b1000
	} state_t;

	state_t state_q;

	logic [mlpp_pkg::WORD_BITS-1:0] frame_mem [DEPTH];
	logic [mlpp_pkg::WORD_BITS-1:0] rdata_q;

	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] wr_addr_q;
	logic [5:0]    wr_bit_q;
	logic          wr_pix_q;
	logic [AW-1:0] rd_base_q;
	logic [2:0]    page_q;
	logic [GW-1:0] grp_q;
	logic          issue_done_q;
	logic          rd_vld_s1;
	logic [GW-1:0] grp_s1;
	logic          rd_last_s1;
	logic          out_vld_q;
	mlpp_pkg::out_t out_q;

	logic [AW-1:0] cmd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [mlpp_pkg::WORD_BITS-1:0] mem_wdata;
	logic [mlpp_pkg::WORD_BITS-1:0] merged;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic          issue;
	logic          load_out;
	logic          grp_end;

	assign cmd_addr = AW'(32'(cmd.page) * GROUPS + 32'(cmd.col[6:3]));
	assign pop = (state_q == S_IDLE) && cmd_valid;
	assign clearing = state_q == S_CLEAR;

	always_comb begin
		merged = rdata_q;
		merged[wr_bit_q] = wr_pix_q;
	end

	assign mem_we = (state_q == S_CLEAR) || (state_q == S_WRITE);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_addr_q : wr_addr_q;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : merged;

	assign load_out = rd_vld_s1 && (!out_vld_q || out_ready);
	assign issue = (state_q == S_READ) && !issue_done_q && (!rd_vld_s1 || load_out);
	assign grp_end = grp_q == GW'(GROUPS - 1);

	assign mem_re = (pop && (cmd.op == mlpp_pkg::CMD_WRITE)) || issue;
	assign mem_raddr = (state_q == S_IDLE) ? cmd_addr : (rd_base_q + AW'(grp_q));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= frame_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wr_addr_q <= cmd_addr;
			wr_bit_q <= {cmd.col[2:0], ~cmd.rsub};
			wr_pix_q <= cmd.pixel;
			rd_base_q <= cmd_addr;
			page_q <= cmd.page;
		end
		if (issue) begin
			grp_s1 <= grp_q;
			rd_last_s1 <= grp_end;
		end
		if (load_out) begin
			out_q.page_out <= page_q;
			out_q.column_group <= 4'(grp_s1);
			out_q.packed_bytes <= rdata_q ^ {mlpp_pkg::WORD_BITS{~invert}};
			out_q.last <= rd_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_addr_q <= '0;
			grp_q <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (issue) begin
				rd_vld_s1 <= 1'b1;
				grp_q <= grp_q + GW'(1);
				if (grp_end) begin
					issue_done_q <= 1'b1;
				end
			end else if (load_out) begin
				rd_vld_s1 <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						case (cmd.op)
							mlpp_pkg::CMD_WRITE: begin
								state_q <= S_WRITE;
							end
							mlpp_pkg::CMD_CLEAR: begin
								clr_addr_q <= '0;
								state_q <= S_CLEAR;
							end
							mlpp_pkg::CMD_READ: begin
								grp_q <= '0;
								issue_done_q <= 1'b0;
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WRITE: begin
					state_q <= S_IDLE;
				end
				S_READ: begin
					if (load_out && rd_last_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign out_data = out_q;

	a_pending_read_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == S_READ)
		else $error("A page read is pending outside a readout.");

	a_clear_addr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> 32'(clr_addr_q) < DEPTH)
		else $error("The clearing sweep left the store.");

	a_last_ends_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && load_out && rd_last_s1) |=> state_q == S_IDLE && !rd_vld_s1)
		else $error("The readout did not end after its last result.");

endmodule

// ----- tb/mono_lcd_page_packer_core_tb.sv -----
`timescale 1ns / 1ps

module mono_lcd_page_packer_core_tb;

	localparam int WIDTH_PX = 128;
	localparam int PAGES = 8;
	localparam int GROUPS = WIDTH_PX / 8;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 360;
	localparam int SETTLE_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;

	class page_readout_checker;
		logic [7:0] frame[WIDTH_PX * PAGES];
		logic invert;
		mlpp_pkg::out_t pending_words[$];
		int errors;

		function new();
			wipe_frame();
			invert = 1'b0;
			errors = 0;
		endfunction

		function void wipe_frame();
			foreach (frame[i])
				frame[i] = 8'h00;
		endfunction

		function void set_invert(logic v);
			invert = v;
		endfunction

		function void note_command(mlpp_pkg::in_t cmd);
			int addr;
			mlpp_pkg::out_t w;
			logic [7:0] b;
			case (cmd.mode)
				mlpp_pkg::MODE_WRITE: begin
					addr = int'(cmd.row[5:3]) * WIDTH_PX + int'(cmd.col);
					frame[addr][7 - int'(cmd.row[2:0])] = cmd.pixel;
				end
				mlpp_pkg::MODE_CLEAR: wipe_frame();
				mlpp_pkg::MODE_READ: begin
					for (int g = 0; g < GROUPS; g++) begin
						w.page_out = cmd.page_sel;
						w.column_group = g[3:0];
						w.last = (g == GROUPS - 1);
						for (int k = 0; k < 8; k++) begin
							b = frame[int'(cmd.page_sel) * WIDTH_PX + g * 8 + k];
							w.packed_bytes[8 * k +: 8] = invert ? b : ~b;
						end
						pending_words.push_back(w);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_word(mlpp_pkg::out_t got);
			mlpp_pkg::out_t want;
			if (pending_words.size() == 0) begin
				$display("%0t: page word expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_words.pop_front();
			if (got.page_out !== want.page_out) begin
				$display("%0t: page_out expected %h actual %h", $time, want.page_out, got.page_out);
				errors++;
			end
			if (got.column_group !== want.column_group) begin
				$display("%0t: column_group expected %h actual %h", $time,
					want.column_group, got.column_group);
				errors++;
			end
			if (got.packed_bytes !== want.packed_bytes) begin
				$display("%0t: packed_bytes expected %h actual %h", $time,
					want.packed_bytes, got.packed_bytes);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %b actual %b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	mlpp_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mlpp_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	page_readout_checker book;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int stall_count = 0;
	logic [2:0] hot_page = 3'd0;

	mono_lcd_page_packer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				book.set_invert(cfg_wdata);
			if (in_valid && in_ready)
				book.note_command(in_data);
			if (out_valid && out_ready)
				book.check_word(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("mono_lcd_page_packer_core_tb: FAIL");
				$finish;
			end
		end
	end

	function automatic mlpp_pkg::in_t make_cmd(logic [1:0] mode, logic [5:0] row,
			logic [6:0] col, logic pixel, logic [2:0] page_sel);
		mlpp_pkg::in_t c;
		c.mode = mode;
		c.row = row;
		c.col = col;
		c.pixel = pixel;
		c.page_sel = page_sel;
		return c;
	endfunction

	function automatic mlpp_pkg::in_t random_cmd();
		mlpp_pkg::in_t c;
		int r;
		c = make_cmd(mlpp_pkg::MODE_WRITE, 6'($urandom_range(63)), 7'($urandom_range(127)),
			1'($urandom_range(1)), 3'($urandom_range(7)));
		if ($urandom_range(15) == 0)
			hot_page = 3'($urandom_range(7));
		r = $urandom_range(99);
		if (r < 3)
			c.mode = mlpp_pkg::MODE_CLEAR;
		else if (r < 7)
			c.mode = MODE_UNUSED;
		else if (r < 25) begin
			c.mode = mlpp_pkg::MODE_READ;
			if ($urandom_range(9) < 6)
				c.page_sel = hot_page;
		end else if ($urandom_range(1)) begin
			c.row[5:3] = hot_page;
		end
		return c;
	endfunction

	task automatic send_cmd(input mlpp_pkg::in_t cmd);
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= cmd;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_invert(input logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (book.pending_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		mlpp_pkg::in_t cmd;
		int n;
		book = new();
		src_idle_pct = 10;
		snk_idle_pct = 66;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		write_invert(1'b0);

		// A fresh store reads as all ones, then the corners of the screen are set and read back.
		send_cmd(make_cmd(mlpp_pkg::MODE_READ, 6'd0, 7'd0, 1'b0, 3'd0));
		send_cmd(make_cmd(mlpp_pkg::MODE_WRITE, 6'd0, 7'd0, 1'b1, 3'd0));
		send_cmd(make_cmd(mlpp_pkg::MODE_WRITE, 6'd7, 7'd0, 1'b1, 3'd0));
		send_cmd(make_cmd(mlpp_pkg::MODE_WRITE, 6'd0, 7'd127, 1'b1, 3'd0));
		send_cmd(make_cmd(mlpp_pkg::MODE_WRITE, 6'd63, 7'd127, 1'b1, 3'd7));
		send_cmd(make_cmd(mlpp_pkg::MODE_WRITE, 6'd56, 7'd0, 1'b1, 3'd7));
		send_cmd(make_cmd(mlpp_pkg::MODE_WRITE, 6'd63, 7'd0, 1'b1, 3'd7));
		send_cmd(make_cmd(mlpp_pkg::MODE_READ, 6'd0, 7'd0, 1'b0, 3'd0));
		send_cmd(make_cmd(mlpp_pkg::MODE_READ, 6'd63, 7'd127, 1'b1, 3'd7));
		send_cmd(make_cmd(mlpp_pkg::MODE_WRITE, 6'd0, 7'd0, 1'b0, 3'd0));
		send_cmd(make_cmd(mlpp_pkg::MODE_WRITE, 6'd31, 7'd64, 1'b1, 3'd3));
		send_cmd(make_cmd(MODE_UNUSED, 6'd63, 7'd127, 1'b1, 3'd7));
		send_cmd(make_cmd(mlpp_pkg::MODE_READ, 6'd0, 7'd0, 1'b0, 3'd0));
		send_cmd(make_cmd(mlpp_pkg::MODE_READ, 6'd0, 7'd0, 1'b0, 3'd3));
		send_cmd(make_cmd(mlpp_pkg::MODE_CLEAR, 6'd63, 7'd127, 1'b1, 3'd7));
		send_cmd(make_cmd(mlpp_pkg::MODE_READ, 6'd0, 7'd0, 1'b0, 3'd7));
		send_cmd(make_cmd(mlpp_pkg::MODE_WRITE, 6'd40, 7'd85, 1'b1, 3'd5));
		send_cmd(make_cmd(mlpp_pkg::MODE_READ, 6'd21, 7'd42, 1'b0, 3'd5));

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			src_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 66 : 0;
			snk_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 10 : 0;
			write_invert(phase != 1);
			n = 0;
			while (n < RANDOM_ITEMS / 3) begin
				cmd = random_cmd();
				send_cmd(cmd);
				if (cmd.mode != MODE_UNUSED)
					n++;
			end
		end

		drain();
		if (book.errors == 0 && book.pending_words.size() == 0)
			$display("mono_lcd_page_packer_core_tb: PASS");
		else
			$display("mono_lcd_page_packer_core_tb: FAIL");
		$finish;
	end

endmodule
